@@ hdl/string_literal_escape_decoder_assert.svh @@
// Assertion macros shared by the string escape decoder modules.
`ifndef STRING_LITERAL_ESCAPE_DECODER_ASSERT_SVH
`define STRING_LITERAL_ESCAPE_DECODER_ASSERT_SVH
`ifndef SYNTH
// Checks that cons holds in the same cycle whenever ante holds.
`define SLSED_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("slsed assertion failed");
// Checks that cons holds in the cycle after ante holds.
`define SLSED_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("slsed assertion failed");
`else
`define SLSED_ASSERT_SAME(lbl, ante, cons)
`define SLSED_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

@@ hdl/slsed_pkg.sv @@
// Types, constants and helper functions of the string escape decoder.
`timescale 1ns / 1ps

package slsed_pkg;

  // Result queue depth; two free entries are needed to take one input beat.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Characters with a special meaning inside a string body.
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_NEWLINE   = 8'h0A;
  localparam logic [7:0] CH_ZERO      = 8'h30;
  localparam logic [7:0] CH_SEVEN     = 8'h37;
  localparam logic [7:0] CH_A         = 8'h61;
  localparam logic [7:0] CH_B         = 8'h62;
  localparam logic [7:0] CH_F         = 8'h66;
  localparam logic [7:0] CH_N         = 8'h6E;
  localparam logic [7:0] CH_R         = 8'h72;
  localparam logic [7:0] CH_T         = 8'h74;
  localparam logic [7:0] CH_V         = 8'h76;

  typedef enum logic [1:0] {
    MODE_NORMAL,
    MODE_ESCAPE,
    MODE_OCT1,
    MODE_OCT2
  } mode_t;

  typedef enum logic [1:0] {
    ERR_NONE,
    ERR_NEWLINE,
    ERR_EOI
  } err_t;

  typedef struct packed {
    logic [7:0] data;
    logic       data_valid;
    logic       done;
    err_t       err;
    logic       line;
  } result_t;

  // Results produced by one input beat, oldest in r0.
  typedef struct packed {
    logic [1:0] count;
    result_t    r0;
    result_t    r1;
  } push_t;

  localparam result_t RESULT_ZERO = '{data: 8'h00, data_valid: 1'b0, done: 1'b0,
                                      err: ERR_NONE, line: 1'b0};

  function automatic logic [7:0] escape_value(input logic [7:0] c);
    logic [7:0] v;
    case (c)
      CH_A:    v = 8'd7;
      CH_B:    v = 8'd8;
      CH_F:    v = 8'd12;
      CH_N:    v = 8'd10;
      CH_R:    v = 8'd13;
      CH_T:    v = 8'd9;
      CH_V:    v = 8'd11;
      default: v = c;
    endcase
    return v;
  endfunction

  function automatic result_t data_result(input logic [7:0] d);
    result_t r;
    r = RESULT_ZERO;
    r.data = d;
    r.data_valid = 1'b1;
    return r;
  endfunction

  function automatic result_t done_result(input err_t e);
    result_t r;
    r = RESULT_ZERO;
    r.done = 1'b1;
    r.err = e;
    return r;
  endfunction

endpackage

@@ hdl/slsed_core.sv @@
// Escape decoding state and the per-beat decode logic.
`timescale 1ns / 1ps
`include "string_literal_escape_decoder_assert.svh"

module slsed_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               fire,
  input  logic [7:0]         byte_q,
  input  logic               eoi_q,
  output slsed_pkg::push_t   push
);

  slsed_pkg::mode_t   mode;
  slsed_pkg::mode_t   mode_next;
  logic [7:0]         octal_value;
  logic [7:0]         octal_value_next;

  // Plain byte handling, used in normal mode and after a cut-short octal escape.
  logic               norm_has;
  slsed_pkg::result_t norm_res;
  slsed_pkg::mode_t   norm_mode;
  logic               is_oct;
  logic [7:0]         oct_shift;

  always_comb begin
    is_oct    = (byte_q inside {[slsed_pkg::CH_ZERO:slsed_pkg::CH_SEVEN]});
    oct_shift = {octal_value[4:0], byte_q[2:0]};

    norm_has  = 1'b1;
    norm_mode = slsed_pkg::MODE_NORMAL;
    norm_res  = slsed_pkg::data_result(byte_q);
    if (byte_q == slsed_pkg::CH_BACKSLASH) begin
      norm_has  = 1'b0;
      norm_mode = slsed_pkg::MODE_ESCAPE;
      norm_res  = slsed_pkg::RESULT_ZERO;
    end else if (byte_q == slsed_pkg::CH_QUOTE) begin
      norm_res = slsed_pkg::done_result(slsed_pkg::ERR_NONE);
    end else if (byte_q == slsed_pkg::CH_NEWLINE) begin
      norm_res = slsed_pkg::done_result(slsed_pkg::ERR_NEWLINE);
    end
  end

  always_comb begin
    push             = '{count: 2'd0, r0: slsed_pkg::RESULT_ZERO,
                         r1: slsed_pkg::RESULT_ZERO};
    mode_next        = mode;
    octal_value_next = octal_value;

    if (eoi_q) begin
      // End of input flushes any pending octal value, then reports the error.
      mode_next        = slsed_pkg::MODE_NORMAL;
      octal_value_next = 8'h00;
      if (mode == slsed_pkg::MODE_OCT1 || mode == slsed_pkg::MODE_OCT2) begin
        push.count = 2'd2;
        push.r0    = slsed_pkg::data_result(octal_value);
        push.r1    = slsed_pkg::done_result(slsed_pkg::ERR_EOI);
      end else begin
        push.count = 2'd1;
        push.r0    = slsed_pkg::done_result(slsed_pkg::ERR_EOI);
      end
    end else begin
      case (mode)
        slsed_pkg::MODE_NORMAL: begin
          push.count = {1'b0, norm_has};
          push.r0    = norm_res;
          mode_next  = norm_mode;
          if (norm_res.done) begin
            octal_value_next = 8'h00;
          end
        end
        slsed_pkg::MODE_ESCAPE: begin
          if (byte_q == slsed_pkg::CH_NEWLINE) begin
            push.count   = 2'd1;
            push.r0.line = 1'b1;
            mode_next    = slsed_pkg::MODE_NORMAL;
          end else if (is_oct) begin
            octal_value_next = {5'd0, byte_q[2:0]};
            mode_next        = slsed_pkg::MODE_OCT1;
          end else begin
            push.count = 2'd1;
            push.r0    = slsed_pkg::data_result(slsed_pkg::escape_value(byte_q));
            mode_next  = slsed_pkg::MODE_NORMAL;
          end
        end
        default: begin
          if (is_oct && mode == slsed_pkg::MODE_OCT1) begin
            octal_value_next = oct_shift;
            mode_next        = slsed_pkg::MODE_OCT2;
          end else if (is_oct) begin
            // Third digit closes the escape.
            push.count       = 2'd1;
            push.r0          = slsed_pkg::data_result(oct_shift);
            mode_next        = slsed_pkg::MODE_NORMAL;
            octal_value_next = 8'h00;
          end else begin
            // A non-octal byte ends the escape and is then taken as a plain byte.
            push.count       = norm_has ? 2'd2 : 2'd1;
            push.r0          = slsed_pkg::data_result(octal_value);
            push.r1          = norm_res;
            mode_next        = norm_mode;
            octal_value_next = 8'h00;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= slsed_pkg::MODE_NORMAL;
      octal_value <= 8'h00;
    end else if (fire) begin
      mode        <= mode_next;
      octal_value <= octal_value_next;
    end
  end

  `SLSED_ASSERT_NEXT(a_eoi_returns_normal, fire && eoi_q, mode == slsed_pkg::MODE_NORMAL && octal_value == 8'h00)
  `SLSED_ASSERT_SAME(a_octal_mode_no_result, fire && !eoi_q && mode == slsed_pkg::MODE_OCT1 && is_oct, push.count == 2'd0)

endmodule

@@ hdl/slsed_outq.sv @@
// Small result queue that takes up to two results per cycle and gives one.
`timescale 1ns / 1ps
`include "string_literal_escape_decoder_assert.svh"

module slsed_outq (
  input  logic               clk,
  input  logic               rst,
  input  slsed_pkg::push_t   push,
  input  logic               pop,
  output slsed_pkg::result_t head,
  output logic               not_empty,
  output logic               room2
);

  slsed_pkg::result_t                 entries [slsed_pkg::QDEPTH];
  logic [slsed_pkg::QPTR_W-1:0]       wr_ptr;
  logic [slsed_pkg::QPTR_W-1:0]       rd_ptr;
  logic [slsed_pkg::QCNT_W-1:0]       count;
  logic [slsed_pkg::QCNT_W-1:0]       count_next;
  logic [slsed_pkg::QPTR_W-1:0]       wr_ptr1;

  assign wr_ptr1   = wr_ptr + slsed_pkg::QPTR_W'(1);
  assign head      = entries[rd_ptr];
  assign not_empty = (count != '0);
  assign room2     = (count <= slsed_pkg::QCNT_W'(slsed_pkg::QDEPTH - 2));
  assign count_next = count + slsed_pkg::QCNT_W'(push.count)
                    - slsed_pkg::QCNT_W'(pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + slsed_pkg::QPTR_W'(push.count);
      if (pop) begin
        rd_ptr <= rd_ptr + slsed_pkg::QPTR_W'(1);
      end
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      entries[wr_ptr] <= push.r0;
    end
    if (push.count == 2'd2) begin
      entries[wr_ptr1] <= push.r1;
    end
  end

  `SLSED_ASSERT_SAME(a_push_has_room, push.count != 2'd0, room2)
  `SLSED_ASSERT_NEXT(a_pop_only_drains, pop && push.count == 2'd0, count == $past(count) - slsed_pkg::QCNT_W'(1))

endmodule

@@ hdl/string_literal_escape_decoder.sv @@
// Top level of the string literal escape decoder.
`timescale 1ns / 1ps
`include "string_literal_escape_decoder_assert.svh"

// The block decodes the body of a quoted string, one raw byte per input beat
// (item_valid / item_stall, payload byte_in and end_of_input), and sends the
// decoded results on the result channel (result_valid / result_stall, payload
// byte_out, byte_valid, string_done, error_code, line_advance).
// Each input beat yields zero, one or two result beats: escape prefixes and
// leading octal digits yield none, an octal escape cut short by end of input
// or by a byte other than a backslash yields two.
// An accepted beat lands in an input register, is decoded once the queue has
// room for its results and has them written into a four-entry result queue;
// the head of the queue is offered on the result channel.
// A new input beat is taken every cycle as long as the queue has two free
// entries, so the block sustains one input beat per cycle while the receiver
// keeps up and no beat yields two results; the rate is bounded only by the
// one result beat per cycle that leaves the queue.
// When the receiver stalls, results stay in the queue, and once it holds more
// than two the input register holds its beat and item_stall rises.
// Reset empties the queue and the input register and puts the decoder back
// in normal mode with no pending octal value.

module string_literal_escape_decoder (
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  output logic       item_stall,
  input  logic [7:0] byte_in,
  input  logic       end_of_input,
  output logic       result_valid,
  input  logic       result_stall,
  output logic [7:0] byte_out,
  output logic       byte_valid,
  output logic       string_done,
  output logic [1:0] error_code,
  output logic       line_advance
);

  // Input register.
  logic               item_q_valid;
  logic [7:0]         byte_q;
  logic               eoi_q;

  logic               room2;
  logic               fire;
  logic               pop;
  slsed_pkg::push_t   push;
  slsed_pkg::push_t   push_gated;
  slsed_pkg::result_t head;

  // The held beat moves on whenever the queue can take its results.
  assign fire       = item_q_valid && room2;
  assign item_stall = item_q_valid && !room2;
  assign pop        = result_valid && !result_stall;

  always_comb begin
    push_gated = push;
    if (!fire) begin
      push_gated.count = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_q_valid <= 1'b0;
    end else if (item_valid && !item_stall) begin
      item_q_valid <= 1'b1;
    end else if (fire) begin
      item_q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      byte_q <= byte_in;
      eoi_q  <= end_of_input;
    end
  end

  slsed_core u_core (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .byte_q (byte_q),
    .eoi_q  (eoi_q),
    .push   (push)
  );

  slsed_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (push_gated),
    .pop       (pop),
    .head      (head),
    .not_empty (result_valid),
    .room2     (room2)
  );

  assign byte_out     = head.data;
  assign byte_valid   = head.data_valid;
  assign string_done  = head.done;
  assign error_code   = head.err;
  assign line_advance = head.line;

  `SLSED_ASSERT_NEXT(a_stalled_beat_kept, item_q_valid && item_stall, item_q_valid && $stable(byte_q) && $stable(eoi_q))

endmodule
